// ===== rtl/cpu_tick_hot_pc_profiler_assert.svh =====
// Assertion macros used by the profiler checker.
`ifndef CPU_TICK_HOT_PC_PROFILER_ASSERT_SVH
`define CPU_TICK_HOT_PC_PROFILER_ASSERT_SVH

// Condition that must hold at every clock edge outside reset.
`define HPP_ASSERT(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("profiler check failed");

// Antecedent at one edge implies the consequent at the next edge.
`define HPP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("profiler check failed");

`endif

// ===== rtl/hpp_pkg.sv =====
package hpp_pkg;

  localparam int          CFG_W       = 4;
  localparam logic [3:0]  GRAIN_RESET = 4'd4;
  localparam int          SLOT_IDX_W  = 4;

  localparam logic KIND_TICK   = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  typedef struct packed {
    logic [63:0] pc;
    logic [31:0] hits;
  } slot_t;

  typedef struct packed {
    logic [63:0] ticks_all;
    logic [63:0] ticks_busy;
    logic [15:0] peak;
    logic [31:0] samples;
    logic [63:0] lr;
    logic [15:0] task_id;
  } cpu_row_t;

  typedef struct packed {
    logic                  found;
    logic [SLOT_IDX_W-1:0] match_idx;
    logic [SLOT_IDX_W-1:0] worst_idx;
    logic [SLOT_IDX_W-1:0] best_idx;
  } scan_res_t;

  typedef struct packed {
    logic        dropped;
    logic [63:0] ticks_all;
    logic [63:0] ticks_busy;
    logic [15:0] runq_peak;
    logic        hot_valid;
    logic [63:0] hot_pc;
    logic [31:0] hot_hits;
    logic [31:0] samples_total;
    logic [63:0] last_return_addr;
    logic [15:0] last_task;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN1,
    ST_SCAN2,
    ST_WRITE
  } state_t;

  function automatic logic [63:0] sat_inc64(input logic [63:0] v);
    sat_inc64 = (v == '1) ? v : v + 64'd1;
  endfunction

  function automatic logic [31:0] sat_inc32(input logic [31:0] v);
    sat_inc32 = (v == '1) ? v : v + 32'd1;
  endfunction

endpackage

// ===== rtl/cpu_tick_hot_pc_profiler.sv =====
// Per-cpu tick accounting with a hot-PC slot table.
// Input channel (tick_valid / tick_stall): one item per transfer, either a
// timer tick sample (kind 0) or a report-and-clear (kind 1) for cpu_index.
// Result channel (res_valid / res_stall): exactly one result per item.
// grain_shift is to be written through grain_shift_we / grain_shift_wdata
// only while idle by the user; the block does not enforce it. Items are
// handled one at a time. Per-cpu counters and the cpu's slot row are read
// from two memories, updated in registers and written back. The slot row
// is scanned one slot per cycle, twice: once to find a match or the
// replacement victim, once to find the hottest slot after the update.
// Items step through ST_LOAD, ST_SCAN1, ST_SCAN2 and ST_WRITE (a dropped cpu
// index goes straight to ST_WRITE); the next item is taken the cycle after
// the result is loaded. A finished result waits in the output register while
// res_stall is high; the block holds its write-back (and tick_stall stays
// high) until that register frees up.
// Reset is synchronous: all counters and slots read as zero afterwards and
// grain_shift returns to 4. No clearing pass is needed.
module cpu_tick_hot_pc_profiler import hpp_pkg::*; #(
  parameter int NUM_CPUS      = 4,
  parameter int SLOTS_PER_CPU = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             grain_shift_we,
  input  logic [CFG_W-1:0] grain_shift_wdata,
  input  logic             tick_valid,
  output logic             tick_stall,
  input  logic             kind,
  input  logic [7:0]       cpu_index,
  input  logic             local_ready,
  input  logic             busy_req,
  input  logic [15:0]      run_queue_len,
  input  logic [63:0]      sample_pc,
  input  logic [63:0]      sample_lr,
  input  logic [15:0]      task_id,
  output logic             res_valid,
  input  logic             res_stall,
  output logic             dropped,
  output logic [63:0]      ticks_all,
  output logic [63:0]      ticks_busy,
  output logic [15:0]      runq_peak,
  output logic             hot_valid,
  output logic [63:0]      hot_pc,
  output logic [31:0]      hot_hits,
  output logic [31:0]      samples_total,
  output logic [63:0]      last_return_addr,
  output logic [15:0]      last_task
);

  localparam int CPU_W  = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
  localparam int SL_W   = (SLOTS_PER_CPU > 1) ? $clog2(SLOTS_PER_CPU) : 1;
  localparam int ROW_W  = $bits(cpu_row_t);
  localparam int SROW_W = SLOTS_PER_CPU * $bits(slot_t);

  state_t state, state_next;

  logic [CFG_W-1:0] grain_shift;
  logic             accept;
  logic             in_range;
  logic [63:0]      pc_mask;

  logic             item_kind;
  logic [CPU_W-1:0] item_cpu;
  logic             item_ready;
  logic             item_busy;
  logic [15:0]      item_rq;
  logic [63:0]      item_pc;
  logic [63:0]      item_lr;
  logic [15:0]      item_task;
  logic             item_drop;

  cpu_row_t                 cpu_rd, cur_row, row_upd, row_wr;
  slot_t [SLOTS_PER_CPU-1:0] slot_rd, slots, slots_upd, slots_wr;

  logic      mem_re, mem_we;
  logic      scan_start, scan_done;
  scan_res_t scan_res;
  logic      sample_en;
  logic      out_load;
  slot_t     best;
  result_t   res_d, res_q;

  assign accept   = tick_valid && !tick_stall;
  assign in_range = {1'b0, cpu_index} < 9'(NUM_CPUS);
  assign pc_mask  = ~((64'd1 << grain_shift) - 64'd1);
  assign sample_en = (item_kind == KIND_TICK) && item_ready && item_busy;

  hpp_row_mem #(
    .DEPTH (NUM_CPUS),
    .AW    (CPU_W),
    .WIDTH (ROW_W)
  ) u_cpu_mem (
    .clk   (clk),
    .rst   (rst),
    .we    (mem_we),
    .waddr (item_cpu),
    .wdata (row_wr),
    .re    (mem_re),
    .raddr (cpu_index[CPU_W-1:0]),
    .rdata (cpu_rd)
  );

  hpp_row_mem #(
    .DEPTH (NUM_CPUS),
    .AW    (CPU_W),
    .WIDTH (SROW_W)
  ) u_slot_mem (
    .clk   (clk),
    .rst   (rst),
    .we    (mem_we),
    .waddr (item_cpu),
    .wdata (slots_wr),
    .re    (mem_re),
    .raddr (cpu_index[CPU_W-1:0]),
    .rdata (slot_rd)
  );

  hpp_slot_scan #(
    .SLOTS (SLOTS_PER_CPU)
  ) u_scan (
    .clk   (clk),
    .rst   (rst),
    .start (scan_start),
    .pc    (item_pc),
    .slots (slots),
    .done  (scan_done),
    .res   (scan_res)
  );

  // tick counter update on the row just read
  always_comb begin
    row_upd = cpu_rd;
    if (item_kind == KIND_TICK) begin
      row_upd.ticks_all = sat_inc64(cpu_rd.ticks_all);
      if (item_ready) begin
        if (item_rq > cpu_rd.peak) begin
          row_upd.peak = item_rq;
        end
        if (item_busy) begin
          row_upd.ticks_busy = sat_inc64(cpu_rd.ticks_busy);
          row_upd.samples    = sat_inc32(cpu_rd.samples);
          row_upd.lr         = item_lr;
          row_upd.task_id    = item_task;
        end
      end
    end
  end

  always_comb begin
    slots_upd = slots;
    if (scan_res.found) begin
      slots_upd[scan_res.match_idx[SL_W-1:0]].hits =
        sat_inc32(slots[scan_res.match_idx[SL_W-1:0]].hits);
    end else begin
      slots_upd[scan_res.worst_idx[SL_W-1:0]].pc   = item_pc;
      slots_upd[scan_res.worst_idx[SL_W-1:0]].hits = 32'd1;
    end
  end

  // a report writes back the row with the per-report state cleared
  always_comb begin
    row_wr   = cur_row;
    slots_wr = slots;
    if (item_kind == KIND_REPORT) begin
      row_wr.samples = '0;
      row_wr.peak    = '0;
      slots_wr       = '0;
    end
  end

  assign best = slots[scan_res.best_idx[SL_W-1:0]];

  always_comb begin
    res_d = '0;
    if (item_drop) begin
      res_d.dropped = 1'b1;
    end else begin
      res_d.ticks_all        = cur_row.ticks_all;
      res_d.ticks_busy       = cur_row.ticks_busy;
      res_d.runq_peak        = cur_row.peak;
      res_d.samples_total    = cur_row.samples;
      res_d.last_return_addr = cur_row.lr;
      res_d.last_task        = cur_row.task_id;
      if ((cur_row.samples != 32'd0) && (best.hits != 32'd0)) begin
        res_d.hot_valid = 1'b1;
        res_d.hot_pc    = best.pc;
        res_d.hot_hits  = best.hits;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = in_range ? ST_LOAD : ST_WRITE;
        end
      end
      ST_LOAD:  state_next = ST_SCAN1;
      ST_SCAN1: begin
        if (scan_done) begin
          state_next = ST_SCAN2;
        end
      end
      ST_SCAN2: begin
        if (scan_done) begin
          state_next = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    tick_stall = (state != ST_IDLE);
    mem_re     = (state == ST_IDLE) && tick_valid && in_range;
    scan_start = (state == ST_LOAD) || ((state == ST_SCAN1) && scan_done);
    out_load   = (state == ST_WRITE) && (!res_valid || !res_stall);
    mem_we     = out_load && !item_drop;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      res_valid   <= 1'b0;
      grain_shift <= GRAIN_RESET;
    end else begin
      state <= state_next;
      if (grain_shift_we) begin
        grain_shift <= grain_shift_wdata;
      end
      if (out_load) begin
        res_valid <= 1'b1;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_kind  <= kind;
      item_cpu   <= cpu_index[CPU_W-1:0];
      item_ready <= local_ready;
      item_busy  <= busy_req;
      item_rq    <= run_queue_len;
      item_pc    <= sample_pc & pc_mask;
      item_lr    <= sample_lr;
      item_task  <= task_id;
      item_drop  <= !in_range;
    end
    if (state == ST_LOAD) begin
      cur_row <= row_upd;
      slots   <= slot_rd;
    end
    if ((state == ST_SCAN1) && scan_done && sample_en) begin
      slots <= slots_upd;
    end
    if (out_load) begin
      res_q <= res_d;
    end
  end

  assign dropped          = res_q.dropped;
  assign ticks_all        = res_q.ticks_all;
  assign ticks_busy       = res_q.ticks_busy;
  assign runq_peak        = res_q.runq_peak;
  assign hot_valid        = res_q.hot_valid;
  assign hot_pc           = res_q.hot_pc;
  assign hot_hits         = res_q.hot_hits;
  assign samples_total    = res_q.samples_total;
  assign last_return_addr = res_q.last_return_addr;
  assign last_task        = res_q.last_task;

endmodule

// ===== rtl/hpp_row_mem.sv =====
module hpp_row_mem #(
  parameter int DEPTH = 4,
  parameter int AW    = 2,
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] filled;
  logic [WIDTH-1:0] rd_q;
  logic             rd_filled;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_q <= mem[raddr];
    end
  end

  // rows never written since reset read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      filled    <= '0;
      rd_filled <= 1'b0;
    end else begin
      if (we) begin
        filled[waddr] <= 1'b1;
      end
      if (re) begin
        rd_filled <= filled[raddr];
      end
    end
  end

  assign rdata = rd_filled ? rd_q : '0;

endmodule

// ===== rtl/hpp_slot_scan.sv =====
module hpp_slot_scan import hpp_pkg::*; #(
  parameter int SLOTS = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [63:0]            pc,
  input  slot_t [SLOTS-1:0]      slots,
  output logic                   done,
  output scan_res_t              res
);

  localparam int SL_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic            busy;
  logic [SL_W-1:0] idx;
  logic            last;
  logic            hit;
  logic [31:0]     worst_hits;
  logic [31:0]     best_hits;
  slot_t           cur;

  assign cur  = slots[idx];
  assign last = (idx == SL_W'(SLOTS - 1));
  assign hit  = (cur.hits != 32'd0) && (cur.pc == pc);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      idx  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        idx  <= '0;
      end else if (busy) begin
        if (last) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          idx <= idx + 1'b1;
        end
      end
    end
  end

  // one slot per cycle: first match, first minimum, first maximum
  always_ff @(posedge clk) begin
    if (busy) begin
      if (idx == '0) begin
        res.found     <= hit;
        res.match_idx <= '0;
        res.worst_idx <= '0;
        res.best_idx  <= '0;
        worst_hits    <= cur.hits;
        best_hits     <= cur.hits;
      end else begin
        if (!res.found && hit) begin
          res.found     <= 1'b1;
          res.match_idx <= SLOT_IDX_W'(idx);
        end
        if (cur.hits < worst_hits) begin
          res.worst_idx <= SLOT_IDX_W'(idx);
          worst_hits    <= cur.hits;
        end
        if (cur.hits > best_hits) begin
          res.best_idx <= SLOT_IDX_W'(idx);
          best_hits    <= cur.hits;
        end
      end
    end
  end

endmodule

// ===== rtl/hpp_checker.sv =====
`include "cpu_tick_hot_pc_profiler_assert.svh"

module hpp_checker (
  input logic        clk,
  input logic        rst,
  input logic        tick_valid,
  input logic        tick_stall,
  input logic        res_valid,
  input logic        res_stall,
  input logic        dropped,
  input logic [63:0] ticks_all,
  input logic [63:0] ticks_busy,
  input logic        hot_valid,
  input logic [63:0] hot_pc,
  input logic [31:0] hot_hits,
  input logic [31:0] samples_total
);

  // one item in flight: a transfer closes the input until its result is out
  `HPP_ASSERT_NEXT(a_one_in_flight, tick_valid && !tick_stall, tick_stall)

  `HPP_ASSERT_NEXT(a_res_held, res_valid && res_stall, res_valid)

  `HPP_ASSERT(a_drop_zero, !(res_valid && dropped) || (ticks_all == 64'd0 && !hot_valid))

  `HPP_ASSERT(a_hot_consistent, !(res_valid && !hot_valid) || (hot_pc == 64'd0 && hot_hits == 32'd0))

  // hits of the hot slot never exceed samples_total; busy ticks never exceed ticks
  `HPP_ASSERT(a_counts_ordered, !res_valid || (hot_hits <= samples_total && ticks_busy <= ticks_all))

endmodule

bind cpu_tick_hot_pc_profiler hpp_checker u_hpp_checker (.*);

// ===== test/tb_cpu_tick_hot_pc_profiler.sv =====
`timescale 1ns / 1ps

module tb_cpu_tick_hot_pc_profiler;
  import hpp_pkg::*;

  localparam int CPUS  = 4;
  localparam int SLOTS = 4;

  typedef struct {
    logic        kind;
    logic [7:0]  cpu;
    logic        ready;
    logic        busy;
    logic [15:0] rq;
    logic [63:0] pc;
    logic [63:0] lr;
    logic [15:0] task_id;
  } tick_item_t;

  // Per-cpu tick/hot-spot shadow plus the queue of predicted results.
  class profile_scoreboard;
    logic [63:0] all_ticks  [CPUS];
    logic [63:0] busy_ticks [CPUS];
    logic [15:0] peak_rq    [CPUS];
    logic [31:0] sample_cnt [CPUS];
    logic [63:0] last_lr    [CPUS];
    logic [15:0] last_tid   [CPUS];
    logic [63:0] slot_pc    [CPUS][SLOTS];
    logic [31:0] slot_hits  [CPUS][SLOTS];
    logic [3:0]  grain;
    result_t     pending[$];
    int          errors, n_checked, n_ticks, n_reports, n_dropped, n_grains;

    function new();
      foreach (all_ticks[c]) begin
        all_ticks[c]  = '0;
        busy_ticks[c] = '0;
        peak_rq[c]    = '0;
        sample_cnt[c] = '0;
        last_lr[c]    = '0;
        last_tid[c]   = '0;
        for (int s = 0; s < SLOTS; s++) begin
          slot_pc[c][s]   = '0;
          slot_hits[c][s] = '0;
        end
      end
      grain = GRAIN_RESET;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("[%0t] MISMATCH %s", $time, msg);
    endtask

    function void set_grain(logic [3:0] g);
      grain = g;
      n_grains++;
    endfunction

    function void take_sample(int c, logic [63:0] pc, logic [63:0] lr, logic [15:0] tid);
      int          worst;
      logic [63:0] rounded;
      worst = 0;
      last_lr[c]  = lr;
      last_tid[c] = tid;
      rounded = pc & ~((64'd1 << grain) - 64'd1);
      if (sample_cnt[c] != '1) sample_cnt[c]++;
      for (int i = 0; i < SLOTS; i++) begin
        if (slot_hits[c][i] != 0 && slot_pc[c][i] == rounded) begin
          if (slot_hits[c][i] != '1) slot_hits[c][i]++;
          return;
        end
        // victim: least hits, lowest index on ties; scan stops at a match
        if (slot_hits[c][i] < slot_hits[c][worst]) worst = i;
      end
      slot_pc[c][worst]   = rounded;
      slot_hits[c][worst] = 32'd1;
    endfunction

    function result_t hot_summary(int c);
      result_t r;
      int      best;
      logic    ok;
      best = 0;
      for (int k = 1; k < SLOTS; k++)
        if (slot_hits[c][k] > slot_hits[c][best]) best = k;
      ok = sample_cnt[c] != 0 && slot_hits[c][best] != 0;
      r = '0;
      r.ticks_all        = all_ticks[c];
      r.ticks_busy       = busy_ticks[c];
      r.runq_peak        = peak_rq[c];
      r.hot_valid        = ok;
      r.hot_pc           = ok ? slot_pc[c][best] : '0;
      r.hot_hits         = ok ? slot_hits[c][best] : '0;
      r.samples_total    = sample_cnt[c];
      r.last_return_addr = last_lr[c];
      r.last_task        = last_tid[c];
      return r;
    endfunction

    function void note_item(tick_item_t it);
      result_t r;
      int      c;
      c = int'(it.cpu);
      if (it.cpu >= CPUS) begin
        r = '0;
        r.dropped = 1'b1;
        n_dropped++;
        pending.push_back(r);
        return;
      end
      if (it.kind == KIND_TICK) begin
        n_ticks++;
        if (all_ticks[c] != '1) all_ticks[c]++;
        if (it.ready) begin
          if (it.busy) begin
            if (busy_ticks[c] != '1) busy_ticks[c]++;
            take_sample(c, it.pc, it.lr, it.task_id);
          end
          if (it.rq > peak_rq[c]) peak_rq[c] = it.rq;
        end
        pending.push_back(hot_summary(c));
      end else begin
        // report shows the state before the clear; tick counts and last sample stay
        n_reports++;
        pending.push_back(hot_summary(c));
        sample_cnt[c] = '0;
        peak_rq[c]    = '0;
        for (int k = 0; k < SLOTS; k++) begin
          slot_pc[c][k]   = '0;
          slot_hits[c][k] = '0;
        end
      end
    endfunction

    task compare(string what, logic [63:0] got, logic [63:0] want);
      if (got !== want)
        report($sformatf("%s got %h want %h (result %0d)", what, got, want, n_checked));
    endtask

    task check_result(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        report("result transfer with no item outstanding");
        return;
      end
      want = pending.pop_front();
      compare("dropped",          64'(got.dropped),          64'(want.dropped));
      compare("ticks_all",        got.ticks_all,             want.ticks_all);
      compare("ticks_busy",       got.ticks_busy,            want.ticks_busy);
      compare("runq_peak",        64'(got.runq_peak),        64'(want.runq_peak));
      compare("hot_valid",        64'(got.hot_valid),        64'(want.hot_valid));
      compare("hot_pc",           got.hot_pc,                want.hot_pc);
      compare("hot_hits",         64'(got.hot_hits),         64'(want.hot_hits));
      compare("samples_total",    64'(got.samples_total),    64'(want.samples_total));
      compare("last_return_addr", got.last_return_addr,      want.last_return_addr);
      compare("last_task",        64'(got.last_task),        64'(want.last_task));
      n_checked++;
    endtask
  endclass

  logic             clk;
  logic             rst;
  logic             grain_shift_we;
  logic [CFG_W-1:0] grain_shift_wdata;
  logic             tick_valid;
  logic             tick_stall;
  logic             kind;
  logic [7:0]       cpu_index;
  logic             local_ready;
  logic             busy_req;
  logic [15:0]      run_queue_len;
  logic [63:0]      sample_pc;
  logic [63:0]      sample_lr;
  logic [15:0]      task_id;
  logic             res_valid;
  logic             res_stall;
  logic             dropped;
  logic [63:0]      ticks_all;
  logic [63:0]      ticks_busy;
  logic [15:0]      runq_peak;
  logic             hot_valid;
  logic [63:0]      hot_pc;
  logic [31:0]      hot_hits;
  logic [31:0]      samples_total;
  logic [63:0]      last_return_addr;
  logic [15:0]      last_task;

  profile_scoreboard board;
  tick_item_t        stim_q[$];

  cpu_tick_hot_pc_profiler #(
    .NUM_CPUS      (CPUS),
    .SLOTS_PER_CPU (SLOTS)
  ) DUT (
    .clk               (clk),
    .rst               (rst),
    .grain_shift_we    (grain_shift_we),
    .grain_shift_wdata (grain_shift_wdata),
    .tick_valid        (tick_valid),
    .tick_stall        (tick_stall),
    .kind              (kind),
    .cpu_index         (cpu_index),
    .local_ready       (local_ready),
    .busy_req          (busy_req),
    .run_queue_len     (run_queue_len),
    .sample_pc         (sample_pc),
    .sample_lr         (sample_lr),
    .task_id           (task_id),
    .res_valid         (res_valid),
    .res_stall         (res_stall),
    .dropped           (dropped),
    .ticks_all         (ticks_all),
    .ticks_busy        (ticks_busy),
    .runq_peak         (runq_peak),
    .hot_valid         (hot_valid),
    .hot_pc            (hot_pc),
    .hot_hits          (hot_hits),
    .samples_total     (samples_total),
    .last_return_addr  (last_return_addr),
    .last_task         (last_task)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("Regression FAIL");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall)
      board.check_result({dropped, ticks_all, ticks_busy, runq_peak, hot_valid, hot_pc,
                          hot_hits, samples_total, last_return_addr, last_task});
  end

  // Result-side backpressure: random modes, plus one long hold-off mid run.
  initial begin
    int mode, span;
    bit held;
    held = 1'b0;
    res_stall <= 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 150);
      for (int n = 0; n < span; n++) begin
        @(posedge clk);
        if (!held && board != null && board.n_checked >= 250) begin
          held = 1'b1;
          res_stall <= 1'b1;
          repeat (400) @(posedge clk);
        end
        case (mode)
          0: res_stall <= 1'b0;
          1: res_stall <= ($urandom_range(0, 99) < 30);
          2: res_stall <= (n % 4 == 1);
          default: res_stall <= ($urandom_range(0, 99) < 85);
        endcase
      end
    end
  end

  function automatic void push_item(logic k, logic [7:0] cpu, logic ready, logic busy,
                                    logic [15:0] rq, logic [63:0] pc, logic [63:0] lr,
                                    logic [15:0] tid);
    tick_item_t it;
    it.kind    = k;
    it.cpu     = cpu;
    it.ready   = ready;
    it.busy    = busy;
    it.rq      = rq;
    it.pc      = pc;
    it.lr      = lr;
    it.task_id = tid;
    stim_q.push_back(it);
  endfunction

  // Mostly well-formed busy ticks on valid cpus hitting a small address pool.
  function automatic void gen_random(int count);
    logic [63:0] pool [6];
    tick_item_t  it;
    foreach (pool[i]) pool[i] = {$urandom, $urandom};
    // near neighbors: separate at fine grains, merged at coarse ones
    pool[1] = pool[0] ^ (64'd1 << $urandom_range(0, 14));
    pool[2] = pool[0] ^ (64'd1 << $urandom_range(0, 14));
    for (int i = 0; i < count; i++) begin
      it.kind  = ($urandom_range(0, 99) < 8) ? KIND_REPORT : KIND_TICK;
      it.cpu   = ($urandom_range(0, 99) < 88) ? 8'($urandom_range(0, CPUS - 1))
                                              : 8'($urandom_range(0, 255));
      it.ready = ($urandom_range(0, 99) < 90);
      it.busy  = ($urandom_range(0, 99) < 80);
      it.rq    = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
      case ($urandom_range(0, 9))
        0: it.pc = {$urandom, $urandom};
        1: it.pc = '0;
        default: it.pc = pool[$urandom_range(0, 5)] ^ 64'($urandom_range(0, 255));
      endcase
      it.lr      = {$urandom, $urandom};
      it.task_id = 16'($urandom);
      stim_q.push_back(it);
    end
  endfunction

  // Sends the queued items in bursts with idle gaps; payload holds while stalled.
  task automatic send_all();
    tick_item_t it;
    int         burst;
    bit         idle;
    burst = $urandom_range(1, 12);
    idle  = 1'b0;
    while (stim_q.size() > 0) begin
      it = stim_q.pop_front();
      tick_valid    <= 1'b1;
      kind          <= it.kind;
      cpu_index     <= it.cpu;
      local_ready   <= it.ready;
      busy_req      <= it.busy;
      run_queue_len <= it.rq;
      sample_pc     <= it.pc;
      sample_lr     <= it.lr;
      task_id       <= it.task_id;
      idle = 1'b0;
      do @(posedge clk); while (tick_stall);
      board.note_item(it);
      burst--;
      if (burst == 0) begin
        tick_valid <= 1'b0;
        idle = 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        burst = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
      end
    end
    if (!idle) tick_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    int n;
    n = 0;
    while (board.pending.size() != 0 && n < 100000) begin
      @(posedge clk);
      n++;
    end
    repeat (2 * SLOTS + 8) @(posedge clk);
  endtask

  task automatic write_grain(logic [3:0] g);
    grain_shift_we    <= 1'b1;
    grain_shift_wdata <= g;
    @(posedge clk);
    grain_shift_we    <= 1'b0;
    board.set_grain(g);
  endtask

  initial begin
    logic [3:0] grains [8];
    board = new();
    rst               <= 1'b1;
    grain_shift_we    <= 1'b0;
    grain_shift_wdata <= '0;
    tick_valid        <= 1'b0;
    kind              <= KIND_TICK;
    cpu_index         <= '0;
    local_ready       <= 1'b0;
    busy_req          <= 1'b0;
    run_queue_len     <= '0;
    sample_pc         <= '0;
    sample_lr         <= '0;
    task_id           <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed pass at the reset grain
    push_item(KIND_REPORT, 8'd0, 1, 1, 16'd5, 64'h1000, 64'h2000, 16'd1);   // empty report
    push_item(KIND_TICK, 8'd0, 0, 1, 16'hFFFF, '1, '1, 16'hFFFF);           // no sched data
    push_item(KIND_TICK, 8'd0, 1, 0, 16'hFFFF, '1, '1, 16'hFFFF);           // idle tick, peak
    push_item(KIND_TICK, 8'd0, 1, 1, 16'd0, '1, '1, 16'hFFFF);
    push_item(KIND_TICK, 8'd0, 1, 1, 16'd1, 64'hFFFF_FFFF_FFFF_FFF3, 64'h0, 16'h0); // same grain
    push_item(KIND_TICK, 8'd0, 1, 1, 16'd2, '0, '0, '0);                    // pc of zero
    push_item(KIND_TICK, 8'd0, 1, 1, 16'd3, 64'h8000_0000_0000_0000, 64'h5555, 16'h1234);
    push_item(KIND_TICK, 8'd0, 1, 1, 16'd4, 64'h10, 64'hAAAA, 16'h4321);
    push_item(KIND_TICK, 8'd0, 1, 1, 16'd5, 64'h1234, 64'h1, 16'h2);        // evicts lowest tie
    push_item(KIND_TICK, 8'd0, 1, 1, 16'd6, 64'h0, 64'h2, 16'h3);
    push_item(KIND_REPORT, 8'd0, 0, 0, '0, '0, '0, '0);
    push_item(KIND_TICK, 8'd1, 1, 1, 16'd9, 64'hA000, 64'h11, 16'h11);
    push_item(KIND_TICK, 8'd1, 1, 1, 16'd9, 64'hB000, 64'h12, 16'h12);
    push_item(KIND_TICK, 8'd1, 1, 1, 16'd9, 64'hB00F, 64'h13, 16'h13);
    push_item(KIND_TICK, 8'd1, 1, 1, 16'd9, 64'hA00F, 64'h14, 16'h14);      // tied best slots
    push_item(KIND_REPORT, 8'd1, 1, 1, '1, '1, '1, '1);
    push_item(KIND_TICK, 8'd3, 1, 1, 16'd7, 64'hDEAD_BEEF_0000_0040, '1, 16'h7);
    push_item(KIND_TICK, 8'd4, 1, 1, '1, '1, '1, '1);                       // out of range
    push_item(KIND_REPORT, 8'd255, 1, 1, '1, '1, '1, '1);
    push_item(KIND_TICK, 8'd128, 1, 1, 16'd1, 64'h1, 64'h1, 16'h1);
    push_item(KIND_REPORT, 8'd3, 0, 0, '0, '0, '0, '0);
    push_item(KIND_TICK, 8'd2, 1, 1, 16'd7, 64'h7777, 64'h8888, 16'h9);
    push_item(KIND_REPORT, 8'd2, 0, 0, '0, '0, '0, '0);
    push_item(KIND_REPORT, 8'd2, 0, 0, '0, '0, '0, '0);                     // right after clear
    send_all();
    wait_idle();

    grains = '{4'd0, 4'd15, 4'd12, 4'd13, 4'd1, 4'($urandom_range(0, 15)), 4'd14,
               4'($urandom_range(0, 15))};
    foreach (grains[p]) begin
      write_grain(grains[p]);
      gen_random(110);
      send_all();
      wait_idle();
    end

    while (board.pending.size() > 0) begin
      board.report("expected result never arrived");
      board.pending.delete(0);
    end

    $display("Covered %0d ticks, %0d reports, %0d out-of-range items; %0d results checked",
             board.n_ticks, board.n_reports, board.n_dropped, board.n_checked);
    $display("Grain shift: reset value plus %0d writes incl. 0, 12..15; %0d mismatches",
             board.n_grains, board.errors);
    if (board.errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
